@@ hw/rtl/scgr_pkg.sv @@
// Shared types, constants and the font lookup of the scaled glyph cell renderer.
`default_nettype none

package scgr_pkg;

  // Glyph geometry: five columns of eight dots each.
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 8;
  localparam int GLYPH_CELLS   = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int CELL_W        = $clog2(GLYPH_CELLS);
  localparam int ROW_W         = $clog2(GLYPH_ROWS);

  // Glyph codes: digits 0 to 9, a blank, anything above is dropped.
  localparam logic [3:0] BLANK_CODE = 4'd10;

  // Dot size register limits.
  localparam logic [3:0] SCALE_RESET = 4'd4;
  localparam logic [3:0] SCALE_MIN   = 4'd1;
  localparam logic [3:0] SCALE_MAX   = 4'd8;

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified glyph request, ready for the back end to render.
  typedef struct packed {
    logic [15:0]            origin_x;
    logic [15:0]            origin_y;
    logic [15:0]            fore_color;
    logic [15:0]            back_color;
    logic [GLYPH_CELLS-1:0] dots;   // column 0 in the low byte, bit j is row j
    logic [3:0]             scale;  // clamped to 1..8
    logic [6:0]             area;   // scale squared
  } cmd_t;

  // Font ROM: returns the five column bytes of a glyph, column 0 lowest.
  function automatic logic [GLYPH_CELLS-1:0] font_dots(input logic [3:0] code);
    logic [GLYPH_CELLS-1:0] d;
    d = '0;
    unique case (code)
      4'd0:    d = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      4'd1:    d = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      4'd2:    d = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      4'd3:    d = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      4'd4:    d = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      4'd5:    d = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      4'd6:    d = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      4'd7:    d = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      4'd8:    d = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      4'd9:    d = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scaled_glyph_cell_renderer_top.sv @@
// Throughput: one rectangle per cycle while out_ready holds, paced by the back end cell walk.
// Requests with codes above ten are taken when the queue has room and produce no rectangles.
// A two-entry command queue lets requests be taken while a glyph is still being drawn.
// Reset: synchronous; the scale register returns to 4, the queue empties, no output is valid.
// Top level of the scaled glyph cell renderer.
`default_nettype none

module scaled_glyph_cell_renderer_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   origin_x,
  input  wire logic [15:0]   origin_y,
  input  wire logic [3:0]    glyph_code,
  input  wire logic [15:0]   fore_color,
  input  wire logic [15:0]   back_color,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        col_start,
  output logic [15:0]        col_end,
  output logic [15:0]        row_start,
  output logic [15:0]        row_end,
  output logic [15:0]        fill_color,
  output logic [6:0]         fill_count,
  output logic               last_cell
);

  logic            push_valid;
  logic            push_ready;
  scgr_pkg::cmd_t  push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  scgr_pkg::cmd_t  pop_cmd;
  logic            busy;

  // The scale register takes a write every cycle.
  assign cfg_ready = 1'b1;

  scgr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .glyph_code (glyph_code),
    .fore_color (fore_color),
    .back_color (back_color),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  scgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  scgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .col_start  (col_start),
    .col_end    (col_end),
    .row_start  (row_start),
    .row_end    (row_end),
    .fill_color (fill_color),
    .fill_count (fill_count),
    .last_cell  (last_cell)
  );

  // A waiting command is picked up as soon as the back end is idle.
  a_idle_pickup: assert property (@(posedge clk) disable iff (rst)
    pop_valid && !busy |=> busy)
    else $error("queued command not picked up by idle back end");

  // A valid request with a known code is pushed into the queue on its transfer.
  a_known_code_pushed: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (glyph_code <= scgr_pkg::BLANK_CODE) |-> push_valid && push_ready)
    else $error("known glyph request not queued");

  // Every rectangle covers between one and sixty-four pixels.
  a_fill_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count != 7'd0) && (fill_count <= 7'd64))
    else $error("rectangle pixel count out of range");

  // The back end never drives a rectangle without a glyph having been loaded.
  a_output_needs_glyph: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("rectangle produced with no glyph in progress");

endmodule

`default_nettype wire

@@ hw/rtl/scgr_front.sv @@
// Front end: holds the scale register, classifies requests and looks up the font.
`default_nettype none

module scgr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic [3:0]    cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   origin_x,
  input  wire logic [15:0]   origin_y,
  input  wire logic [3:0]    glyph_code,
  input  wire logic [15:0]   fore_color,
  input  wire logic [15:0]   back_color,
  output logic               push_valid,
  output scgr_pkg::cmd_t     push_cmd,
  input  wire logic          push_ready
);

  logic [3:0] glyph_scale;
  logic [3:0] eff_scale;

  // Scale register keeps whatever bits were written.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale <= scgr_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      glyph_scale <= cfg_data;
    end
  end

  // Clamp the written scale into the usable range.
  always_comb begin
    eff_scale = glyph_scale;
    if (glyph_scale < scgr_pkg::SCALE_MIN) begin
      eff_scale = scgr_pkg::SCALE_MIN;
    end else if (glyph_scale > scgr_pkg::SCALE_MAX) begin
      eff_scale = scgr_pkg::SCALE_MAX;
    end
  end

  // Every request is taken when the queue has room; unknown codes are dropped.
  assign in_ready   = push_ready;
  assign push_valid = in_valid && (glyph_code <= scgr_pkg::BLANK_CODE);

  // Build the command for the back end.
  always_comb begin
    push_cmd.origin_x   = origin_x;
    push_cmd.origin_y   = origin_y;
    push_cmd.fore_color = fore_color;
    push_cmd.back_color = back_color;
    push_cmd.dots       = scgr_pkg::font_dots(glyph_code);
    push_cmd.scale      = eff_scale;
    push_cmd.area       = 7'(eff_scale) * 7'(eff_scale);
  end

endmodule

`default_nettype wire

@@ hw/rtl/scgr_queue.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module scgr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire scgr_pkg::cmd_t push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output scgr_pkg::cmd_t     pop_cmd,
  input  wire logic          pop_ready
);

  scgr_pkg::cmd_t                    mem [scgr_pkg::QUEUE_DEPTH];
  logic [scgr_pkg::QPTR_W-1:0]       wr_ptr;
  logic [scgr_pkg::QPTR_W-1:0]       rd_ptr;
  logic [scgr_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count != scgr_pkg::QCNT_W'(scgr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == scgr_pkg::QPTR_W'(scgr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == scgr_pkg::QPTR_W'(scgr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scgr_back.sv @@
// Back end: walks the forty cells of a glyph and drives the rectangle output register.
`default_nettype none

module scgr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  input  wire scgr_pkg::cmd_t pop_cmd,
  output logic               pop_ready,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        col_start,
  output logic [15:0]        col_end,
  output logic [15:0]        row_start,
  output logic [15:0]        row_end,
  output logic [15:0]        fill_color,
  output logic [6:0]         fill_count,
  output logic               last_cell
);

  scgr_pkg::cmd_t                       cur;
  logic [scgr_pkg::GLYPH_CELLS-1:0]     dots;
  logic [scgr_pkg::CELL_W-1:0]          cell_idx;
  logic [15:0]                          x;
  logic [15:0]                          y;
  logic [15:0]                          side;
  logic                                 advance;
  logic                                 at_last;
  logic                                 row_last;
  logic                                 load;

  assign side     = 16'(cur.scale);
  assign advance  = busy && (!out_valid || out_ready);
  assign at_last  = (cell_idx == scgr_pkg::CELL_W'(scgr_pkg::GLYPH_CELLS - 1));
  assign row_last = (cell_idx[scgr_pkg::ROW_W-1:0] ==
                     scgr_pkg::ROW_W'(scgr_pkg::GLYPH_ROWS - 1));
  assign load     = pop_valid && (!busy || (advance && at_last));
  assign pop_ready = load;

  // Control: glyph in progress and output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (advance && at_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register: one rectangle per transfer.
  always_ff @(posedge clk) begin
    if (advance) begin
      col_start  <= x;
      col_end    <= 16'(x + side - 16'd1);
      row_start  <= y;
      row_end    <= 16'(y + side - 16'd1);
      fill_color <= dots[0] ? cur.fore_color : cur.back_color;
      fill_count <= cur.area;
      last_cell  <= at_last;
    end
  end

  // Cell walk: rows inner, columns outer, coordinates stepped by the scale.
  always_ff @(posedge clk) begin
    if (load) begin
      cur      <= pop_cmd;
      dots     <= pop_cmd.dots;
      x        <= pop_cmd.origin_x;
      y        <= pop_cmd.origin_y;
      cell_idx <= '0;
    end else if (advance) begin
      cell_idx <= cell_idx + 1'b1;
      dots     <= dots >> 1;
      if (row_last) begin
        y <= cur.origin_y;
        x <= 16'(x + side);
      end else begin
        y <= 16'(y + side);
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_scaled_glyph_cell_renderer_top.sv @@
// Self-checking testbench for the scaled glyph cell renderer: random and directed glyph requests.
`default_nettype none

module tb_scaled_glyph_cell_renderer_top;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;

  // One fill rectangle as it appears on the output channel.
  typedef struct packed {
    logic [15:0] col_start;
    logic [15:0] col_end;
    logic [15:0] row_start;
    logic [15:0] row_end;
    logic [15:0] fill_color;
    logic [6:0]  fill_count;
    logic        last_cell;
  } rect_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [15:0] origin_x   = '0;
  logic [15:0] origin_y   = '0;
  logic [3:0]  glyph_code = '0;
  logic [15:0] fore_color = '0;
  logic [15:0] back_color = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [15:0] col_start;
  logic [15:0] col_end;
  logic [15:0] row_start;
  logic [15:0] row_end;
  logic [15:0] fill_color;
  logic [6:0]  fill_count;
  logic        last_cell;

  // Idle percentages of the sender and the receiver for the current phase.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // Long receiver hold-offs: requested by the sequence, served by the receiver.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  // Column bytes of the 5x8 font; bit j of a byte is dot row j.
  function automatic logic [7:0] dot_column(input logic [3:0] code, input int col);
    logic [39:0] cols;
    case (code)
      4'd0:    cols = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      4'd1:    cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      4'd2:    cols = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      4'd3:    cols = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      4'd4:    cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      4'd5:    cols = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      4'd6:    cols = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      4'd7:    cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      4'd8:    cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      4'd9:    cols = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      default: cols = '0;
    endcase
    return cols[39 - 8*col -: 8];
  endfunction

  // Predicts the rectangles of each glyph and checks them in order.
  class glyph_rect_scoreboard;
    rect_t      expected_rects[$];
    logic [3:0] scale_reg;
    int         failures;
    int         reported;

    function new();
      scale_reg = scgr_pkg::SCALE_RESET;
      failures  = 0;
      reported  = 0;
    endfunction

    function void set_scale(input logic [3:0] value);
      scale_reg = value;
    endfunction

    function int outstanding();
      return expected_rects.size();
    endfunction

    // Zero draws as one pixel and anything above eight as eight.
    function logic [15:0] dot_side();
      if (scale_reg < scgr_pkg::SCALE_MIN) return 16'(scgr_pkg::SCALE_MIN);
      if (scale_reg > scgr_pkg::SCALE_MAX) return 16'(scgr_pkg::SCALE_MAX);
      return 16'(scale_reg);
    endfunction

    // Expands one accepted request with a known code into its forty rectangles; other codes give none.
    function void note_request(input logic [15:0] ox, input logic [15:0] oy,
                               input logic [3:0] code, input logic [15:0] fore,
                               input logic [15:0] back);
      logic [15:0] side;
      logic [7:0]  bits;
      rect_t       r;
      int          n;
      if (code > scgr_pkg::BLANK_CODE) return;
      side = dot_side();
      n = 0;
      for (int c = 0; c < scgr_pkg::GLYPH_COLUMNS; c++) begin
        bits = dot_column(code, c);
        for (int j = 0; j < scgr_pkg::GLYPH_ROWS; j++) begin
          r.col_start  = ox + 16'(c) * side;
          r.col_end    = r.col_start + side - 16'd1;
          r.row_start  = oy + 16'(j) * side;
          r.row_end    = r.row_start + side - 16'd1;
          r.fill_color = bits[j] ? fore : back;
          r.fill_count = 7'(side * side);
          r.last_cell  = (n == scgr_pkg::GLYPH_COLUMNS * scgr_pkg::GLYPH_ROWS - 1);
          expected_rects.push_back(r);
          n++;
        end
      end
    endfunction

    // Compares one output transfer with the oldest predicted rectangle.
    function void check_rect(input rect_t got);
      rect_t want;
      if (expected_rects.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS)
          $display("ERROR: rectangle with none expected: cols %h..%h rows %h..%h color %h",
                   got.col_start, got.col_end, got.row_start, got.row_end, got.fill_color);
        reported++;
        return;
      end
      want = expected_rects.pop_front();
      if (got !== want) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          $display("ERROR: rectangle mismatch");
          $display("  expected cols %h..%h rows %h..%h color %h count %0d last %b",
                   want.col_start, want.col_end, want.row_start, want.row_end,
                   want.fill_color, want.fill_count, want.last_cell);
          $display("  actual   cols %h..%h rows %h..%h color %h count %0d last %b",
                   got.col_start, got.col_end, got.row_start, got.row_end,
                   got.fill_color, got.fill_count, got.last_cell);
        end
        reported++;
      end
    endfunction
  endclass

  glyph_rect_scoreboard sb = new();

  scaled_glyph_cell_renderer_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .glyph_code (glyph_code),
    .fore_color (fore_color),
    .back_color (back_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .col_start  (col_start),
    .col_end    (col_end),
    .row_start  (row_start),
    .row_end    (row_end),
    .fill_color (fill_color),
    .fill_count (fill_count),
    .last_cell  (last_cell)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_ready    <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every input transfer feeds the predictor, every output transfer is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(origin_x, origin_y, glyph_code, fore_color, back_color);
      if (out_valid && out_ready)
        sb.check_rect({col_start, col_end, row_start, row_end,
                       fill_color, fill_count, last_cell});
    end
  end

  // Offers one request after a random gap and returns at the edge that takes it.
  task automatic send_glyph(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [3:0] code, input logic [15:0] fore,
                            input logic [15:0] back);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    origin_x   <= ox;
    origin_y   <= oy;
    glyph_code <= code;
    fore_color <= fore;
    back_color <= back;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random request; mostly drawable codes, origins often near the wrap point.
  task automatic send_random_glyph(output bit drawn);
    logic [3:0]  code;
    logic [15:0] ox;
    logic [15:0] oy;
    if ($urandom_range(0, 99) < 85) begin
      code = 4'($urandom_range(0, scgr_pkg::BLANK_CODE));
    end else begin
      code = 4'($urandom_range(scgr_pkg::BLANK_CODE + 1, 15));
    end
    ox = 16'($urandom);
    oy = 16'($urandom);
    if ($urandom_range(0, 3) == 0) ox = 16'hFFFF - 16'($urandom_range(0, 63));
    if ($urandom_range(0, 3) == 0) oy = 16'hFFFF - 16'($urandom_range(0, 63));
    send_glyph(ox, oy, code, 16'($urandom), 16'($urandom));
    drawn = (code <= scgr_pkg::BLANK_CODE);
  endtask

  // Drops valid and waits until every predicted rectangle has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the dot size register through its own channel.
  task automatic write_scale(input logic [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_scale(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit         drawn;
    int         count;
    logic [3:0] scale;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every code at the reset scale, with extreme fields and wrapping origins.
    send_glyph(16'h0000, 16'h0000, 4'd0, 16'hFFFF, 16'h0000);
    send_glyph(16'hFFFF, 16'hFFFF, 4'd1, 16'h0000, 16'hFFFF);
    send_glyph(16'hFFF0, 16'hFFE4, 4'd2, 16'hF800, 16'h07E0);
    for (int k = 3; k < 16; k++)
      send_glyph(16'($urandom), 16'($urandom), 4'(k), 16'($urandom), 16'($urandom));
    wait_drained();

    // Directed: a zero scale draws single pixels.
    write_scale(4'd0);
    send_glyph(16'hFFFE, 16'hFFFB, 4'd8, 16'hAAAA, 16'h5555);
    send_glyph(16'h8000, 16'h7FFF, scgr_pkg::BLANK_CODE, 16'h1234, 16'hFFFF);
    wait_drained();

    // Directed: scales above eight draw eight by eight squares.
    write_scale(4'd15);
    send_glyph(16'hFFE0, 16'hFFC8, 4'd4, 16'hFFFF, 16'h0000);
    send_glyph(16'h0100, 16'h0200, 4'd9, 16'h0F0F, 16'hF0F0);
    wait_drained();
    write_scale(4'd9);
    send_glyph(16'hFFFF, 16'h0000, 4'd7, 16'h0001, 16'h8000);
    wait_drained();

    // Random: three idle patterns, each over several dot sizes.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 22; rx_idle_pct = 83; end
        1:       begin tx_idle_pct = 83; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int chunk = 0; chunk < 5; chunk++) begin
        case (chunk)
          0:       scale = 4'd1;
          1:       scale = 4'd8;
          2:       scale = 4'd0;
          3:       scale = 4'd15;
          default: scale = 4'($urandom_range(0, 15));
        endcase
        write_scale(scale);
        // Back up the output while the sender keeps offering requests.
        if (mode == 2 && chunk == 0) begin
          @(posedge clk);
          hold_requests = hold_requests + 1;
        end
        count = 0;
        while (count < 11) begin
          send_random_glyph(drawn);
          if (drawn) count++;
        end
        wait_drained();
      end
    end

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
